FILE: rtl/srt_pkg.sv
// Shared types and constants for the sorted record table.
`timescale 1ns / 1ps

package srt_pkg;

	localparam int DEPTH = 32;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int ENTRY_COUNT_W = 6;

	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_INSERT = 2'd1;
	localparam logic [1:0] OP_DELETE = 2'd2;
	localparam logic [1:0] OP_DUMP   = 2'd3;

	localparam logic [2:0] ST_DONE     = 3'd0;
	localparam logic [2:0] ST_NOTFOUND = 3'd1;
	localparam logic [2:0] ST_EMPTY    = 3'd2;
	localparam logic [2:0] ST_FULL     = 3'd3;
	localparam logic [2:0] ST_RECORD   = 3'd4;

	typedef struct packed {
		logic [1:0]         operation;
		logic signed [31:0] key;
		logic [31:0]        payload;
	} req_t;

	typedef struct packed {
		logic [2:0]               status;
		logic signed [31:0]       out_key;
		logic [31:0]              out_payload;
		logic [ENTRY_COUNT_W-1:0] entry_count;
		logic                     last;
	} rsp_t;

	typedef struct packed {
		logic signed [31:0] key;
		logic [31:0]        payload;
	} rec_t;

	// per-cell source selects
	typedef struct packed {
		logic take_new;
		logic take_below;
		logic take_above;
	} cell_ctl_t;

	// one bit per cell for each move
	typedef struct packed {
		logic [DEPTH-1:0] load;
		logic [DEPTH-1:0] up;
		logic [DEPTH-1:0] down;
		logic [DEPTH-1:0] wrap;
	} chain_ctl_t;

endpackage

FILE: rtl/srt_cell.sv
// One table cell: holds a record, compares it to the request key, moves with its neighbors.
`timescale 1ns / 1ps

module srt_cell import srt_pkg::*; (
	input  logic      clk,
	input  cell_ctl_t ctl,
	input  rec_t      rec_new,
	input  rec_t      rec_below,
	input  rec_t      rec_above,
	input  logic signed [31:0] req_key,
	output rec_t      rec,
	output logic      ge,
	output logic      eq
);

	rec_t rec_q;

	always_ff @(posedge clk) begin
		priority if (ctl.take_new) begin
			rec_q <= rec_new;
		end else if (ctl.take_below) begin
			rec_q <= rec_below;
		end else if (ctl.take_above) begin
			rec_q <= rec_above;
		end else begin
			rec_q <= rec_q;
		end
	end

	assign rec = rec_q;
	assign ge  = (req_key <= rec_q.key);
	assign eq  = (req_key == rec_q.key);

endmodule

FILE: rtl/srt_chain.sv
// Row of table cells with neighbor wiring and the wrap path used while dumping.
`timescale 1ns / 1ps

module srt_chain import srt_pkg::*; (
	input  logic             clk,
	input  chain_ctl_t       ctl,
	input  rec_t             rec_new,
	input  logic signed [31:0] req_key,
	output logic [DEPTH-1:0] ge,
	output logic [DEPTH-1:0] eq,
	output rec_t             head
);

	rec_t recs [DEPTH];

	assign head = recs[0];

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		rec_t      below;
		rec_t      above;
		cell_ctl_t cctl;

		if (i == 0) begin : g_first
			assign below = rec_new;
		end else begin : g_mid
			assign below = recs[i-1];
		end

		if (i == DEPTH - 1) begin : g_top
			assign above = ctl.wrap[i] ? recs[0] : rec_new;
		end else begin : g_inner
			assign above = ctl.wrap[i] ? recs[0] : recs[i+1];
		end

		assign cctl.take_new   = ctl.load[i];
		assign cctl.take_below = ctl.up[i];
		assign cctl.take_above = ctl.down[i] | ctl.wrap[i];

		srt_cell u_cell (
			.clk       (clk),
			.ctl       (cctl),
			.rec_new   (rec_new),
			.rec_below (below),
			.rec_above (above),
			.req_key   (req_key),
			.rec       (recs[i]),
			.ge        (ge[i]),
			.eq        (eq[i])
		);
	end

endmodule

FILE: rtl/sorted_record_table_unit.sv
// Sorted record table: ordered list of up to DEPTH keyed records in a row of cells.
// Request channel (req_valid/req_stall/req) carries operation, key and payload:
// append at tail, sorted insert before the first entry with key >= request key,
// delete of the first matching key, and dump of all entries in table order.
// Response channel (rsp_valid/rsp_stall/rsp) returns status, key, payload,
// entry count after the operation and a last mark on the final response.
// Append, insert and delete give one response; dump gives one per entry, or a
// single "table empty" response when nothing is held.
// Timing: a request is taken, all cells compare against its key the next cycle,
// and in the execute state, once the output register is free, the row shifts in
// one step and the response is registered. A dump gives one entry per cycle while
// the response is not stalled, as the row rotates by one cell. One request is in
// flight at a time; req_stall is high meanwhile.
// A stalled response holds; the row waits until the output register frees.
// Reset empties the table and drops any pending response; record contents are
// not cleared, only the fill count.
`timescale 1ns / 1ps

module sorted_record_table_unit import srt_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp
);

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_CMP  = 3'b010,
		S_EXEC = 3'b100
	} state_t;

	state_t           state_q;
	req_t             req_q;
	logic [CNT_W-1:0] count_q;
	logic [DEPTH-1:0] flag_q;
	logic [IDX_W-1:0] dump_idx_q;
	rsp_t             rsp_q;
	logic             rsp_valid_q;

	chain_ctl_t       ctl;
	rec_t             rec_new;
	rec_t             head;
	logic [DEPTH-1:0] ge;
	logic [DEPTH-1:0] eq;
	logic [DEPTH-1:0] occ;
	logic [DEPTH-1:0] slot;
	logic [DEPTH-1:0] tail;
	logic [DEPTH-1:0] first;
	logic [DEPTH-1:0] at_above;
	logic             out_free;
	logic             emit;
	logic             done;
	logic             dump_last;
	logic             full;
	logic             empty;
	logic [CNT_W-1:0] count_d;
	rsp_t             rsp_d;

	assign rec_new.key     = req_q.key;
	assign rec_new.payload = req_q.payload;

	srt_chain u_chain (
		.clk     (clk),
		.ctl     (ctl),
		.rec_new (rec_new),
		.req_key (req_q.key),
		.ge      (ge),
		.eq      (eq),
		.head    (head)
	);

	always_comb begin
		for (int i = 0; i < DEPTH; i++) begin
			occ[i] = (CNT_W'(i) < count_q);
		end
	end

	assign slot     = ~occ & {occ[DEPTH-2:0], 1'b1};
	assign tail     = occ & ~{1'b0, occ[DEPTH-1:1]};
	assign first    = flag_q & (~flag_q + DEPTH'(1));
	assign at_above = ~(first - DEPTH'(1));
	assign full     = (count_q == CNT_W'(DEPTH));
	assign empty    = (count_q == '0);
	assign dump_last = ((CNT_W'(dump_idx_q) + CNT_W'(1)) == count_q);

	assign out_free = !rsp_valid_q || !rsp_stall;
	assign emit     = (state_q == S_EXEC) && out_free;

	always_comb begin
		ctl     = '0;
		count_d = count_q;
		done    = 1'b1;
		rsp_d.status      = ST_DONE;
		rsp_d.out_key     = req_q.key;
		rsp_d.out_payload = '0;
		rsp_d.last        = 1'b1;
		unique case (req_q.operation)
			OP_APPEND, OP_INSERT: begin
				if (full) begin
					rsp_d.status = ST_FULL;
				end else begin
					count_d = count_q + CNT_W'(1);
					if (req_q.operation == OP_INSERT && first != '0) begin
						ctl.load = first;
						ctl.up   = at_above & ~first;
					end else begin
						ctl.load = slot;
					end
				end
			end
			OP_DELETE: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else if (first == '0) begin
					rsp_d.status = ST_NOTFOUND;
				end else begin
					ctl.down = at_above;
					count_d  = count_q - CNT_W'(1);
				end
			end
			OP_DUMP: begin
				if (empty) begin
					rsp_d.status = ST_EMPTY;
				end else begin
					// rotate one cell toward the head; the head wraps to the tail
					ctl.down          = occ & ~tail;
					ctl.wrap          = tail;
					rsp_d.status      = ST_RECORD;
					rsp_d.out_key     = head.key;
					rsp_d.out_payload = head.payload;
					rsp_d.last        = dump_last;
					done              = dump_last;
				end
			end
			default: begin
				rsp_d.status = ST_DONE;
			end
		endcase
		rsp_d.entry_count = ENTRY_COUNT_W'(count_d);
		if (!emit) begin
			ctl = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			count_q     <= '0;
			dump_idx_q  <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						state_q <= S_CMP;
					end
				end
				S_CMP: begin
					state_q    <= S_EXEC;
					dump_idx_q <= '0;
				end
				S_EXEC: begin
					if (emit) begin
						count_q <= count_d;
						if (done) begin
							state_q <= S_IDLE;
						end else begin
							dump_idx_q <= dump_idx_q + IDX_W'(1);
						end
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && req_valid) begin
			req_q <= req;
		end
		if (state_q == S_CMP) begin
			flag_q <= ((req_q.operation == OP_INSERT) ? ge : eq) & occ;
		end
		if (emit) begin
			rsp_q <= rsp_d;
		end
	end

	assign req_stall = (state_q != S_IDLE);
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef ASSERT_OFF
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("fill count above table depth");

	a_accept_to_cmp: assert property (@(posedge clk) disable iff (!arst_n)
		(req_valid && !req_stall) |=> (state_q == S_CMP))
		else $error("accepted request did not start compare");

	a_dump_count: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.status == ST_RECORD) |->
		(rsp.entry_count == ENTRY_COUNT_W'(count_q)))
		else $error("dumped record count disagrees with fill count");

	a_ctl_excl: assert property (@(posedge clk) disable iff (!arst_n)
		((ctl.up & ctl.down) == '0) && ((ctl.load & (ctl.down | ctl.wrap)) == '0))
		else $error("cell told to take from two sources");
`endif

endmodule
